>>> hw/rtl/mcbd_pkg.sv
// Package for the multi-click button decoder.
// Holds reset values, register indexes and the structs shared by the top level and the core.
// No dependencies.
package mcbd_pkg;

	localparam int unsigned TIMER_BITS_DEFAULT = 16;
	localparam int unsigned CFG_BITS           = 16;
	localparam int unsigned COUNT_BITS         = 4;

	localparam logic [CFG_BITS-1:0]   GAP_RESET     = 16'd500;
	localparam logic [CFG_BITS-1:0]   LOCKOUT_RESET = 16'd50;
	localparam logic [COUNT_BITS-1:0] MAX_RESET     = 4'd5;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX     = 4'd15;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_GAP     = 2'd0,
		CFG_LOCKOUT = 2'd1,
		CFG_MAX     = 2'd2
	} cfg_idx_t;

	// Current configuration, as seen by the core.
	typedef struct packed {
		logic [CFG_BITS-1:0]   gap_ticks;
		logic [CFG_BITS-1:0]   lockout_ticks;
		logic [COUNT_BITS-1:0] max_clicks;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic                  report_valid;
		logic [COUNT_BITS-1:0] click_total;
		logic                  held_after;
	} res_t;

endpackage

>>> hw/rtl/mcbd_core.sv
// Tick-update core of the multi-click button decoder.
// Holds the timers, click count and flags; computes one result word per step.
// Depends on mcbd_pkg.
module mcbd_core import mcbd_pkg::*; #(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic level,
	input  cfg_t cfg,
	output res_t res
);

	localparam int unsigned CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	logic                  prev_level_q;
	logic                  rearmed_q;
	logic [TIMER_BITS-1:0] lockout_q;
	logic [TIMER_BITS-1:0] since_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  armed_q;
	logic                  held_q;

	logic                  held_d;
	logic                  rearmed_d;
	logic [TIMER_BITS-1:0] lockout_adv;
	logic [TIMER_BITS-1:0] since_adv;
	logic [TIMER_BITS-1:0] lockout_d;
	logic [TIMER_BITS-1:0] since_d;
	logic [COUNT_BITS-1:0] count_inc;
	logic [COUNT_BITS-1:0] count_d;
	logic                  armed_d;
	logic                  lock_done;
	logic                  press;
	logic                  release_seen;
	logic                  gap_hit;
	logic                  max_hit;
	logic                  report;

	// Both timers advance and stop at all ones.
	assign lockout_adv = (lockout_q == TIMER_MAX) ? lockout_q : lockout_q + 1'b1;
	assign since_adv   = (since_q == TIMER_MAX) ? since_q : since_q + 1'b1;
	assign lock_done   = CMP_BITS'(lockout_adv) > CMP_BITS'(cfg.lockout_ticks);

	assign press        = !level && rearmed_q && lock_done;
	assign release_seen = level && lock_done;
	assign count_inc    = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

	// Press and release tests, then the report test.
	always_comb begin
		held_d    = prev_level_q ? 1'b0 : held_q;
		rearmed_d = rearmed_q;
		lockout_d = lockout_adv;
		since_d   = since_adv;
		count_d   = count_q;
		armed_d   = armed_q;
		if (press) begin
			count_d   = count_inc;
			rearmed_d = 1'b0;
			lockout_d = '0;
			since_d   = '0;
			armed_d   = 1'b1;
		end
		if (release_seen) begin
			rearmed_d = 1'b1;
			lockout_d = '0;
		end
		gap_hit = armed_d && (CMP_BITS'(since_d) >= CMP_BITS'(cfg.gap_ticks));
		max_hit = (cfg.max_clicks != '0) && (count_d >= cfg.max_clicks);
		report  = gap_hit || max_hit;
		res.report_valid = report;
		res.click_total  = report ? count_d : '0;
		if (report) begin
			armed_d = 1'b0;
			count_d = '0;
			if (!level) begin
				held_d = 1'b1;
			end
		end
		res.held_after = held_d;
	end

	// State registers, updated once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			rearmed_q    <= 1'b1;
			lockout_q    <= TIMER_MAX;
			since_q      <= '0;
			count_q      <= '0;
			armed_q      <= 1'b0;
			held_q       <= 1'b0;
		end else if (step) begin
			prev_level_q <= level;
			rearmed_q    <= rearmed_d;
			lockout_q    <= lockout_d;
			since_q      <= since_d;
			count_q      <= count_d;
			armed_q      <= armed_d;
			held_q       <= held_d;
		end
	end

`ifndef SYNTH
	// A report clears the sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && report |=> count_q == '0 && !armed_q)
		else $error("click sequence not cleared after report");

	// A reported sequence always holds at least one click.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && report |-> count_d == '0 && res.click_total != '0)
		else $error("empty click sequence reported");

	// The held flag is only raised by a report.
	assert property (@(posedge clk) disable iff (!arst_n)
		!held_q && !(step && report) |=> !held_q)
		else $error("held flag set without report");

	// A counted press restarts both timers and disarms pressing.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && press |=> lockout_q == '0 && !rearmed_q && since_q == '0)
		else $error("press did not restart timers");
`endif

endmodule

>>> hw/rtl/multi_click_button_decoder.sv
// Top level of the multi-click button decoder.
// Input register, configuration registers, core and output register.
// Depends on mcbd_pkg and mcbd_core.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------
//  in       in_valid / in_ready    button_level
//  out      out_valid / out_ready  report_valid, click_total, held_after
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each tick word passes through the input register, then through the core into
// the output register. One word is taken per cycle while the output is not
// stalled; the core updates its state once per accepted word.
// Reset returns configuration to 500 / 50 / 5 and all flags and timers to idle.
// A stalled output holds the pipeline; cfg_ready is always high.
module multi_click_button_decoder import mcbd_pkg::*; #(
	parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  button_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  report_valid,
	output logic [COUNT_BITS-1:0] click_total,
	output logic                  held_after,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	logic level_s1;
	logic out_valid_q;
	res_t res_q;
	res_t res_next;
	logic advance;

	// The core steps when a word waits and the output slot is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks     <= GAP_RESET;
			cfg_q.lockout_ticks <= LOCKOUT_RESET;
			cfg_q.max_clicks    <= MAX_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_GAP:     cfg_q.gap_ticks     <= cfg_data;
				CFG_LOCKOUT: cfg_q.lockout_ticks <= cfg_data;
				CFG_MAX:     cfg_q.max_clicks    <= cfg_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= button_level;
		end
		if (advance) begin
			res_q <= res_next;
		end
	end

	mcbd_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.level (level_s1),
		.cfg   (cfg_q),
		.res   (res_next)
	);

	assign out_valid    = out_valid_q;
	assign report_valid = res_q.report_valid;
	assign click_total  = res_q.click_total;
	assign held_after   = res_q.held_after;

endmodule
